@@ src/elevator_car_controller_core_assert.svh @@
// ----------------------------------------------------------------------------
// elevator car controller assertion macros
// concurrent checks that vanish when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef ELEVATOR_CAR_CONTROLLER_CORE_ASSERT_SVH
`define ELEVATOR_CAR_CONTROLLER_CORE_ASSERT_SVH

`ifndef SYNTH

// same-cycle implication, checked out of reset
`define ECC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define ECC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ECC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg)
`define ECC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

@@ src/ecc_pkg.sv @@
// ----------------------------------------------------------------------------
// ecc_pkg
// shared constants, mode codes and item types of the elevator car controller
// ----------------------------------------------------------------------------
package ecc_pkg;

    // default number of floors served
    localparam int FLOORS_DEF = 4;

    // door timer
    localparam logic [15:0] DOOR_TICKS_RST = 16'd3000;
    localparam logic [15:0] DOOR_CNT_MAX   = 16'hFFFF;

    // car modes
    localparam logic [2:0] M_INIT          = 3'd0;
    localparam logic [2:0] M_IDLE_FLOOR    = 3'd1;
    localparam logic [2:0] M_DRIVE         = 3'd2;
    localparam logic [2:0] M_DOOR          = 3'd3;
    localparam logic [2:0] M_EMERG_FLOOR   = 3'd4;
    localparam logic [2:0] M_EMERG_BETWEEN = 3'd5;
    localparam logic [2:0] M_IDLE_BETWEEN  = 3'd6;

    // travel direction and motor command
    localparam logic [1:0] DIR_STOP = 2'd0;
    localparam logic [1:0] DIR_UP   = 2'd1;
    localparam logic [1:0] DIR_DOWN = 2'd2;

    // button type, also the bit position inside one floor's order group
    localparam logic [1:0] B_CAB  = 2'd0;
    localparam logic [1:0] B_UP   = 2'd1;
    localparam logic [1:0] B_DOWN = 2'd2;

    // one registered input tick
    typedef struct packed {
        logic       stop_pressed;
        logic       at_floor;
        logic [1:0] sensed_floor;
        logic       press_valid;
        logic [1:0] press_button;
        logic [1:0] press_floor;
    } t_in_item;

    // car control state
    typedef struct packed {
        logic [2:0]  mode;
        logic [1:0]  dir;
        logic        mwc;
        logic [15:0] door_cnt;
    } t_car_ctl;

    // one result item
    typedef struct packed {
        logic [1:0]  motor_drive;
        logic        door_lamp;
        logic        stop_lamp;
        logic [1:0]  floor_indicator;
        logic [2:0]  mode;
        logic [11:0] order_lamps;
    } t_out_item;

endpackage

@@ src/ecc_in_if.sv @@
// ----------------------------------------------------------------------------
// ecc_in_if
// input tick channel: stop switch, floor sensor and one button press
// ----------------------------------------------------------------------------
interface ecc_in_if;

    logic       valid;
    logic       ready;
    logic       stop_pressed;
    logic       at_floor;
    logic [1:0] sensed_floor;
    logic       press_valid;
    logic [1:0] press_button;
    logic [1:0] press_floor;

    modport source (
        output valid, stop_pressed, at_floor, sensed_floor,
               press_valid, press_button, press_floor,
        input  ready
    );

    modport sink (
        input  valid, stop_pressed, at_floor, sensed_floor,
               press_valid, press_button, press_floor,
        output ready
    );

endinterface

@@ src/ecc_out_if.sv @@
// ----------------------------------------------------------------------------
// ecc_out_if
// result channel: motor, lamps, floor indicator, mode and order lamps
// ----------------------------------------------------------------------------
interface ecc_out_if;

    logic        valid;
    logic        ready;
    logic [1:0]  motor_drive;
    logic        door_lamp;
    logic        stop_lamp;
    logic [1:0]  floor_indicator;
    logic [2:0]  mode;
    logic [11:0] order_lamps;

    modport source (
        output valid, motor_drive, door_lamp, stop_lamp,
               floor_indicator, mode, order_lamps,
        input  ready
    );

    modport sink (
        input  valid, motor_drive, door_lamp, stop_lamp,
               floor_indicator, mode, order_lamps,
        output ready
    );

endinterface

@@ src/ecc_in_reg.sv @@
// ----------------------------------------------------------------------------
// ecc_in_reg
// input register stage; refills in the cycle its item moves on
// ----------------------------------------------------------------------------
module ecc_in_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    ecc_in_if.sink            i_in,
    input  logic              i_adv,
    output logic              o_valid,
    output ecc_pkg::t_in_item o_item
);

    logic              r_valid;
    ecc_pkg::t_in_item r_item;

    // free when empty or when the held item moves on this cycle
    assign i_in.ready = !r_valid || i_adv;

    // occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_valid <= i_in.valid;
        end
    end

    // payload capture on transfer
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_item.stop_pressed <= i_in.stop_pressed;
            r_item.at_floor     <= i_in.at_floor;
            r_item.sensed_floor <= i_in.sensed_floor;
            r_item.press_valid  <= i_in.press_valid;
            r_item.press_button <= i_in.press_button;
            r_item.press_floor  <= i_in.press_floor;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

@@ src/ecc_car_step.sv @@
// ----------------------------------------------------------------------------
// ecc_car_step
// one tick of the car: order entry, mode step, door timer and result fields
// ----------------------------------------------------------------------------
module ecc_car_step #(
    parameter int  FLOORS = ecc_pkg::FLOORS_DEF,
    localparam int LW     = (FLOORS > 2) ? $clog2(FLOORS) : 1,
    localparam int OW     = 3 * FLOORS
) (
    input  ecc_pkg::t_in_item  i_item,
    input  ecc_pkg::t_car_ctl  i_ctl,
    input  logic [LW-1:0]      i_lf,
    input  logic [OW-1:0]      i_orders,
    input  logic [15:0]        i_door_ticks,
    output ecc_pkg::t_car_ctl  o_ctl,
    output logic [LW-1:0]      o_lf,
    output logic [OW-1:0]      o_orders,
    output ecc_pkg::t_out_item o_res
);

    logic [2:0]          ord [FLOORS];
    logic [FLOORS-1:0]   any_f;
    logic                stop;
    logic                seen;
    logic                press_ok;
    logic [LW-1:0]       sf;
    logic [LW-1:0]       rf;
    logic                rf_any;
    logic                above;
    logic                below;
    logic                above_m1;
    logic                below_p1;
    ecc_pkg::t_car_ctl   c;
    logic [LW-1:0]       lf;
    logic [OW-1:0]       ord_flat;
    logic [OW+11:0]      ord_wide;
    logic [LW+1:0]       lf_wide;

    always_comb begin
        stop = i_item.stop_pressed;
        sf   = LW'(i_item.sensed_floor);
        seen = i_item.at_floor && (int'(i_item.sensed_floor) < FLOORS);

        // button press enters the order bits first
        press_ok = i_item.press_valid && !stop
                && (i_item.press_button <= ecc_pkg::B_DOWN)
                && (int'(i_item.press_floor) < FLOORS)
                && (i_ctl.mode != ecc_pkg::M_INIT)
                && (i_ctl.mode != ecc_pkg::M_EMERG_FLOOR)
                && (i_ctl.mode != ecc_pkg::M_EMERG_BETWEEN);
        for (int g = 0; g < FLOORS; g++) begin
            ord[g] = i_orders[3*g +: 3];
            if (press_ok && (int'(i_item.press_floor) == g)) begin
                case (i_item.press_button)
                    ecc_pkg::B_CAB:  ord[g][ecc_pkg::B_CAB]  = 1'b1;
                    ecc_pkg::B_UP:   ord[g][ecc_pkg::B_UP]   = 1'b1;
                    ecc_pkg::B_DOWN: ord[g][ecc_pkg::B_DOWN] = 1'b1;
                    default: ;
                endcase
            end
        end

        // orders above and below the reference floor
        rf    = (i_ctl.mode == ecc_pkg::M_DRIVE) ? sf : i_lf;
        above = 1'b0;
        below = 1'b0;
        for (int g = 0; g < FLOORS; g++) begin
            any_f[g] = |ord[g];
            if (g > int'(rf)) above = above | any_f[g];
            if (g < int'(rf)) below = below | any_f[g];
        end
        rf_any   = (int'(rf) < FLOORS) ? any_f[rf] : 1'b0;
        above_m1 = above | rf_any;
        below_p1 = below | rf_any;

        // mode step
        c  = i_ctl;
        lf = i_lf;
        case (i_ctl.mode)
            ecc_pkg::M_INIT: begin
                if (seen) begin
                    lf     = sf;
                    c.mode = ecc_pkg::M_IDLE_FLOOR;
                    c.dir  = ecc_pkg::DIR_STOP;
                end
            end
            ecc_pkg::M_IDLE_FLOOR: begin
                if (stop) begin
                    c.mode = ecc_pkg::M_EMERG_FLOOR;
                end else if (ord[lf][ecc_pkg::B_CAB]) begin
                    c.mode = ecc_pkg::M_DOOR;
                    c.door_cnt = '0;
                    c.mwc = 1'b0;
                    ord[lf][ecc_pkg::B_CAB] = 1'b0;
                end else if (ord[lf][ecc_pkg::B_UP]) begin
                    c.mode = ecc_pkg::M_DOOR;
                    c.door_cnt = '0;
                    c.mwc = 1'b0;
                    ord[lf][ecc_pkg::B_UP] = 1'b0;
                end else if (ord[lf][ecc_pkg::B_DOWN]) begin
                    c.mode = ecc_pkg::M_DOOR;
                    c.door_cnt = '0;
                    c.mwc = 1'b0;
                    ord[lf][ecc_pkg::B_DOWN] = 1'b0;
                end else if (2 * int'(lf) + 1 >= FLOORS) begin
                    // upper half prefers going up
                    if (above) begin
                        c.mode = ecc_pkg::M_DRIVE;
                        c.dir  = ecc_pkg::DIR_UP;
                    end else if (below) begin
                        c.mode = ecc_pkg::M_DRIVE;
                        c.dir  = ecc_pkg::DIR_DOWN;
                    end
                end else begin
                    // lower half prefers going down
                    if (below) begin
                        c.mode = ecc_pkg::M_DRIVE;
                        c.dir  = ecc_pkg::DIR_DOWN;
                    end else if (above) begin
                        c.mode = ecc_pkg::M_DRIVE;
                        c.dir  = ecc_pkg::DIR_UP;
                    end
                end
            end
            ecc_pkg::M_DRIVE: begin
                if (stop) begin
                    if (seen) begin
                        lf     = sf;
                        c.mode = ecc_pkg::M_EMERG_FLOOR;
                    end else begin
                        c.mode = ecc_pkg::M_EMERG_BETWEEN;
                    end
                end else if (seen) begin
                    lf = sf;
                    if (i_ctl.dir == ecc_pkg::DIR_UP) begin
                        if (ord[sf][ecc_pkg::B_UP] || ord[sf][ecc_pkg::B_CAB]) begin
                            c.mode = ecc_pkg::M_DOOR;
                            c.door_cnt = '0;
                            c.mwc = 1'b0;
                            ord[sf][ecc_pkg::B_UP]  = 1'b0;
                            ord[sf][ecc_pkg::B_CAB] = 1'b0;
                        end else if (!above && ord[sf][ecc_pkg::B_DOWN]) begin
                            c.mode = ecc_pkg::M_DOOR;
                            c.door_cnt = '0;
                            c.mwc = 1'b0;
                            ord[sf][ecc_pkg::B_DOWN] = 1'b0;
                        end
                    end else if (i_ctl.dir == ecc_pkg::DIR_DOWN) begin
                        if (ord[sf][ecc_pkg::B_DOWN] || ord[sf][ecc_pkg::B_CAB]) begin
                            c.mode = ecc_pkg::M_DOOR;
                            c.door_cnt = '0;
                            c.mwc = 1'b0;
                            ord[sf][ecc_pkg::B_DOWN] = 1'b0;
                            ord[sf][ecc_pkg::B_CAB]  = 1'b0;
                        end else if (!below && ord[sf][ecc_pkg::B_UP]) begin
                            c.mode = ecc_pkg::M_DOOR;
                            c.door_cnt = '0;
                            c.mwc = 1'b0;
                            ord[sf][ecc_pkg::B_UP] = 1'b0;
                        end
                    end
                end
            end
            ecc_pkg::M_DOOR: begin
                if (stop) begin
                    c.mode = ecc_pkg::M_EMERG_FLOOR;
                end else begin
                    // cab button at this floor restarts the timer
                    if (ord[lf][ecc_pkg::B_CAB]) begin
                        ord[lf][ecc_pkg::B_CAB] = 1'b0;
                        c.door_cnt = '0;
                    end
                    // pick the next direction once
                    if (!c.mwc) begin
                        if (above && (c.dir == ecc_pkg::DIR_UP || c.dir == ecc_pkg::DIR_STOP
                                      || !below)) begin
                            c.dir = ecc_pkg::DIR_UP;
                            c.mwc = 1'b1;
                        end else if (below && (c.dir == ecc_pkg::DIR_DOWN
                                               || c.dir == ecc_pkg::DIR_STOP || !above)) begin
                            c.dir = ecc_pkg::DIR_DOWN;
                            c.mwc = 1'b1;
                        end else if (ord[lf][ecc_pkg::B_UP] || ord[lf][ecc_pkg::B_DOWN]) begin
                            ord[lf][ecc_pkg::B_UP]   = 1'b0;
                            ord[lf][ecc_pkg::B_DOWN] = 1'b0;
                            c.door_cnt = '0;
                        end
                    end
                    // hall button matching the chosen direction restarts the timer
                    if (c.mwc) begin
                        if (c.dir == ecc_pkg::DIR_UP && ord[lf][ecc_pkg::B_UP]) begin
                            ord[lf][ecc_pkg::B_UP] = 1'b0;
                            c.door_cnt = '0;
                        end else if (c.dir == ecc_pkg::DIR_DOWN && ord[lf][ecc_pkg::B_DOWN]) begin
                            ord[lf][ecc_pkg::B_DOWN] = 1'b0;
                            c.door_cnt = '0;
                        end
                    end
                    // saturating door timer
                    if (c.door_cnt != ecc_pkg::DOOR_CNT_MAX) begin
                        c.door_cnt = c.door_cnt + 16'd1;
                    end
                    if (c.door_cnt >= i_door_ticks) begin
                        c.door_cnt = '0;
                        if (c.mwc) begin
                            c.mode = ecc_pkg::M_DRIVE;
                        end else begin
                            c.mode = ecc_pkg::M_IDLE_FLOOR;
                            c.dir  = ecc_pkg::DIR_STOP;
                        end
                    end
                end
            end
            ecc_pkg::M_EMERG_FLOOR: begin
                for (int g = 0; g < FLOORS; g++) begin
                    ord[g] = 3'b000;
                end
                if (!stop) begin
                    c.mode = ecc_pkg::M_DOOR;
                    c.door_cnt = '0;
                    c.mwc = 1'b0;
                end
            end
            ecc_pkg::M_EMERG_BETWEEN: begin
                for (int g = 0; g < FLOORS; g++) begin
                    ord[g] = 3'b000;
                end
                if (!stop) begin
                    c.mode = ecc_pkg::M_IDLE_BETWEEN;
                end
            end
            ecc_pkg::M_IDLE_BETWEEN: begin
                if (stop) begin
                    c.mode = ecc_pkg::M_EMERG_BETWEEN;
                end else if (i_ctl.dir == ecc_pkg::DIR_UP) begin
                    if (above) begin
                        c.mode = ecc_pkg::M_DRIVE;
                        c.dir  = ecc_pkg::DIR_UP;
                    end else if (below_p1) begin
                        // reverse: the last floor becomes the one above the car
                        c.mode = ecc_pkg::M_DRIVE;
                        c.dir  = ecc_pkg::DIR_DOWN;
                        if (int'(lf) + 1 < FLOORS) lf = lf + LW'(1);
                    end
                end else if (i_ctl.dir == ecc_pkg::DIR_DOWN) begin
                    if (below) begin
                        c.mode = ecc_pkg::M_DRIVE;
                        c.dir  = ecc_pkg::DIR_DOWN;
                    end else if (above_m1) begin
                        // reverse: the last floor becomes the one below the car
                        c.mode = ecc_pkg::M_DRIVE;
                        c.dir  = ecc_pkg::DIR_UP;
                        if (lf != '0) lf = lf - LW'(1);
                    end
                end
            end
            default: begin
                c.mode = ecc_pkg::M_INIT;
            end
        endcase

        // flatten orders
        for (int g = 0; g < FLOORS; g++) begin
            ord_flat[3*g +: 3] = ord[g];
        end
        ord_wide = {12'b0, ord_flat};
        lf_wide  = {2'b00, lf};

        // next state
        o_ctl    = c;
        o_lf     = lf;
        o_orders = ord_flat;

        // result fields from the state after the tick
        if (c.mode == ecc_pkg::M_DRIVE) begin
            o_res.motor_drive = c.dir;
        end else if (c.mode == ecc_pkg::M_INIT) begin
            o_res.motor_drive = ecc_pkg::DIR_DOWN;
        end else begin
            o_res.motor_drive = ecc_pkg::DIR_STOP;
        end
        o_res.door_lamp = (c.mode == ecc_pkg::M_DOOR) || (c.mode == ecc_pkg::M_EMERG_FLOOR);
        o_res.stop_lamp = (c.mode == ecc_pkg::M_EMERG_FLOOR)
                       || (c.mode == ecc_pkg::M_EMERG_BETWEEN);
        o_res.floor_indicator = lf_wide[1:0];
        o_res.mode            = c.mode;
        o_res.order_lamps     = ord_wide[11:0];
    end

endmodule

@@ src/elevator_car_controller_core.sv @@
// ----------------------------------------------------------------------------
// elevator_car_controller_core
// elevator car controller: order bits, car mode, door timer, motor and lamps
// ----------------------------------------------------------------------------
//  channel   dir  handshake          payload
//  i_in      in   valid / ready      stop, floor sensor, one button press
//  o_out     out  valid / ready      motor, lamps, floor, mode, order lamps
//  i_cfg     in   i_cfg_we           door_open_ticks (16 bit)
//
//  one tick per cycle sustained while o_out is ready; a tick passes the
//  input register, then the car step into the state and result registers
//  the car state loop closes through one pass of short logic each cycle
//  synchronous reset: init descent, no orders, door_open_ticks = 3000
//  a stalled result holds the input stage; both registers refill in the
//  cycle they empty
// ----------------------------------------------------------------------------
`include "elevator_car_controller_core_assert.svh"

module elevator_car_controller_core #(
    parameter int FLOORS = ecc_pkg::FLOORS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    ecc_in_if.sink      i_in,
    ecc_out_if.source   o_out
);

    localparam int LW = (FLOORS > 2) ? $clog2(FLOORS) : 1;
    localparam int OW = 3 * FLOORS;

    logic               in_valid;
    ecc_pkg::t_in_item  in_item;
    logic               adv;

    ecc_pkg::t_car_ctl  r_ctl;
    ecc_pkg::t_car_ctl  n_ctl;
    logic [LW-1:0]      r_lf;
    logic [LW-1:0]      n_lf;
    logic [OW-1:0]      r_orders;
    logic [OW-1:0]      n_orders;
    logic [15:0]        r_door_ticks;
    logic               r_res_valid;
    ecc_pkg::t_out_item r_res;
    ecc_pkg::t_out_item n_res;

    // input register
    ecc_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_adv   (adv),
        .o_valid (in_valid),
        .o_item  (in_item)
    );

    // step the car when the result register can take the item
    assign adv = in_valid && (!r_res_valid || o_out.ready);

    ecc_car_step #(
        .FLOORS (FLOORS)
    ) u_car_step (
        .i_item       (in_item),
        .i_ctl        (r_ctl),
        .i_lf         (r_lf),
        .i_orders     (r_orders),
        .i_door_ticks (r_door_ticks),
        .o_ctl        (n_ctl),
        .o_lf         (n_lf),
        .o_orders     (n_orders),
        .o_res        (n_res)
    );

    // car state, config register and result occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl.mode     <= ecc_pkg::M_INIT;
            r_ctl.dir      <= ecc_pkg::DIR_STOP;
            r_ctl.mwc      <= 1'b0;
            r_ctl.door_cnt <= '0;
            r_lf           <= '0;
            r_orders       <= '0;
            r_door_ticks   <= ecc_pkg::DOOR_TICKS_RST;
            r_res_valid    <= 1'b0;
        end else begin
            if (adv) begin
                r_ctl    <= n_ctl;
                r_lf     <= n_lf;
                r_orders <= n_orders;
            end
            if (i_cfg_we) begin
                r_door_ticks <= i_cfg_wdata;
            end
            if (adv) begin
                r_res_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_res <= n_res;
        end
    end

    // output channel
    assign o_out.valid           = r_res_valid;
    assign o_out.motor_drive     = r_res.motor_drive;
    assign o_out.door_lamp       = r_res.door_lamp;
    assign o_out.stop_lamp       = r_res.stop_lamp;
    assign o_out.floor_indicator = r_res.floor_indicator;
    assign o_out.mode            = r_res.mode;
    assign o_out.order_lamps     = r_res.order_lamps;

    // emergency tick with the switch still held leaves no orders
    `ECC_ASSERT_NEXT(a_emerg_clears, i_clk, i_rst_n,
        adv && in_item.stop_pressed && (r_ctl.mode == ecc_pkg::M_EMERG_FLOOR
            || r_ctl.mode == ecc_pkg::M_EMERG_BETWEEN),
        r_orders == '0, "orders left after an emergency tick")

    // driving always has a direction
    `ECC_ASSERT_NOW(a_drive_dir, i_clk, i_rst_n,
        r_ctl.mode == ecc_pkg::M_DRIVE,
        r_ctl.dir == ecc_pkg::DIR_UP || r_ctl.dir == ecc_pkg::DIR_DOWN,
        "drive mode without a direction")

    // a full input stage only takes a transfer when its item moves on
    `ECC_ASSERT_NOW(a_in_no_overrun, i_clk, i_rst_n,
        i_in.valid && i_in.ready && in_valid, adv,
        "input register overwritten")

    // the result mode tracks the stepped car mode
    `ECC_ASSERT_NEXT(a_res_mode, i_clk, i_rst_n,
        adv, r_res_valid && (r_res.mode == r_ctl.mode),
        "result mode differs from car mode")

endmodule

@@ test/elevator_car_controller_core_chk.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elevator_car_controller_core_chk
// watches the tick and status channels, runs its own car model on every
// accepted tick and compares each status transfer with the oldest prediction
// ----------------------------------------------------------------------------
module elevator_car_controller_core_chk (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    ecc_in_if           in_mon,
    ecc_out_if          out_mon,
    output int          o_fail_count,
    output int          o_awaited,
    output int          o_ticks,
    output logic [7:0]  o_modes_seen
);

    localparam int FLOORS = ecc_pkg::FLOORS_DEF;

    // model of the car
    logic [2:0]            car_mode;
    logic [1:0]            car_dir;
    int                    car_floor;
    logic                  leave_after_door;
    int unsigned           door_cnt;
    logic [3*FLOORS-1:0]   orders;
    logic [15:0]           door_ticks;

    // predicted status items, oldest first
    ecc_pkg::t_out_item    status_q[$];

    function automatic bit has_order(logic [1:0] b, int f);
        if (f < 0 || f >= FLOORS) return 1'b0;
        return orders[3 * f + b];
    endfunction

    function automatic void clear_order(logic [1:0] b, int f);
        if (f >= 0 && f < FLOORS) orders[3 * f + b] = 1'b0;
    endfunction

    function automatic bit floor_busy(int f);
        return has_order(ecc_pkg::B_CAB, f) || has_order(ecc_pkg::B_UP, f)
            || has_order(ecc_pkg::B_DOWN, f);
    endfunction

    function automatic bit orders_above(int f);
        for (int g = f + 1; g < FLOORS; g++)
            if (floor_busy(g)) return 1'b1;
        return 1'b0;
    endfunction

    function automatic bit orders_below(int f);
        for (int g = 0; g < f && g < FLOORS; g++)
            if (floor_busy(g)) return 1'b1;
        return 1'b0;
    endfunction

    function automatic void enter_drive(logic [1:0] d);
        car_mode = ecc_pkg::M_DRIVE;
        car_dir  = d;
    endfunction

    function automatic void enter_idle();
        car_mode = ecc_pkg::M_IDLE_FLOOR;
        car_dir  = ecc_pkg::DIR_STOP;
    endfunction

    function automatic void enter_door();
        car_mode         = ecc_pkg::M_DOOR;
        door_cnt         = 0;
        leave_after_door = 1'b0;
    endfunction

    // one tick of the car: press registration, then one state step
    function automatic ecc_pkg::t_out_item advance_car(ecc_pkg::t_in_item t);
        ecc_pkg::t_out_item r;
        bit        halt;
        bit        seen;
        int        sf;
        int        lf;
        halt = t.stop_pressed;
        sf   = int'(t.sensed_floor);
        seen = t.at_floor && sf < FLOORS;
        lf   = car_floor;

        if (t.press_valid && !halt && t.press_button <= ecc_pkg::B_DOWN
            && t.press_floor < FLOORS
            && car_mode != ecc_pkg::M_INIT && car_mode != ecc_pkg::M_EMERG_FLOOR
            && car_mode != ecc_pkg::M_EMERG_BETWEEN)
            orders[3 * t.press_floor + t.press_button] = 1'b1;

        case (car_mode)
            ecc_pkg::M_INIT: begin
                if (seen) begin
                    car_floor = sf;
                    enter_idle();
                end
            end
            ecc_pkg::M_IDLE_FLOOR: begin
                if (halt) begin
                    car_mode = ecc_pkg::M_EMERG_FLOOR;
                end else if (has_order(ecc_pkg::B_CAB, lf)) begin
                    enter_door();
                    clear_order(ecc_pkg::B_CAB, lf);
                end else if (has_order(ecc_pkg::B_UP, lf)) begin
                    enter_door();
                    clear_order(ecc_pkg::B_UP, lf);
                end else if (has_order(ecc_pkg::B_DOWN, lf)) begin
                    enter_door();
                    clear_order(ecc_pkg::B_DOWN, lf);
                end else if (2 * lf + 1 >= FLOORS) begin
                    // upper half prefers going up
                    if (orders_above(lf)) enter_drive(ecc_pkg::DIR_UP);
                    else if (orders_below(lf)) enter_drive(ecc_pkg::DIR_DOWN);
                end else begin
                    if (orders_below(lf)) enter_drive(ecc_pkg::DIR_DOWN);
                    else if (orders_above(lf)) enter_drive(ecc_pkg::DIR_UP);
                end
            end
            ecc_pkg::M_DRIVE: begin
                if (halt) begin
                    if (seen) begin
                        car_floor = sf;
                        car_mode  = ecc_pkg::M_EMERG_FLOOR;
                    end else begin
                        car_mode = ecc_pkg::M_EMERG_BETWEEN;
                    end
                end else if (seen) begin
                    car_floor = sf;
                    if (car_dir == ecc_pkg::DIR_UP) begin
                        if (has_order(ecc_pkg::B_UP, sf) || has_order(ecc_pkg::B_CAB, sf)) begin
                            enter_door();
                            clear_order(ecc_pkg::B_UP, sf);
                            clear_order(ecc_pkg::B_CAB, sf);
                        end else if (!orders_above(sf) && has_order(ecc_pkg::B_DOWN, sf)) begin
                            enter_door();
                            clear_order(ecc_pkg::B_DOWN, sf);
                        end
                    end else if (car_dir == ecc_pkg::DIR_DOWN) begin
                        if (has_order(ecc_pkg::B_DOWN, sf)
                            || has_order(ecc_pkg::B_CAB, sf)) begin
                            enter_door();
                            clear_order(ecc_pkg::B_DOWN, sf);
                            clear_order(ecc_pkg::B_CAB, sf);
                        end else if (!orders_below(sf) && has_order(ecc_pkg::B_UP, sf)) begin
                            enter_door();
                            clear_order(ecc_pkg::B_UP, sf);
                        end
                    end
                end
            end
            ecc_pkg::M_DOOR: begin
                if (halt) begin
                    car_mode = ecc_pkg::M_EMERG_FLOOR;
                end else begin
                    // cab order at this floor restarts the timer
                    if (has_order(ecc_pkg::B_CAB, lf)) begin
                        clear_order(ecc_pkg::B_CAB, lf);
                        door_cnt = 0;
                    end
                    // pick the next direction once
                    if (!leave_after_door) begin
                        if (orders_above(lf) && (car_dir == ecc_pkg::DIR_UP
                            || car_dir == ecc_pkg::DIR_STOP || !orders_below(lf))) begin
                            car_dir          = ecc_pkg::DIR_UP;
                            leave_after_door = 1'b1;
                        end else if (orders_below(lf) && (car_dir == ecc_pkg::DIR_DOWN
                            || car_dir == ecc_pkg::DIR_STOP || !orders_above(lf))) begin
                            car_dir          = ecc_pkg::DIR_DOWN;
                            leave_after_door = 1'b1;
                        end else if (has_order(ecc_pkg::B_UP, lf)
                                     || has_order(ecc_pkg::B_DOWN, lf)) begin
                            clear_order(ecc_pkg::B_UP, lf);
                            clear_order(ecc_pkg::B_DOWN, lf);
                            door_cnt = 0;
                        end
                    end
                    // hall call in the leaving direction keeps the door open
                    if (leave_after_door) begin
                        if (car_dir == ecc_pkg::DIR_UP && has_order(ecc_pkg::B_UP, lf)) begin
                            clear_order(ecc_pkg::B_UP, lf);
                            door_cnt = 0;
                        end else if (car_dir == ecc_pkg::DIR_DOWN
                                     && has_order(ecc_pkg::B_DOWN, lf)) begin
                            clear_order(ecc_pkg::B_DOWN, lf);
                            door_cnt = 0;
                        end
                    end
                    // saturating timer
                    if (door_cnt < ecc_pkg::DOOR_CNT_MAX) door_cnt++;
                    if (door_cnt >= door_ticks) begin
                        door_cnt = 0;
                        if (leave_after_door) enter_drive(car_dir);
                        else enter_idle();
                    end
                end
            end
            ecc_pkg::M_EMERG_FLOOR: begin
                orders = '0;
                if (!halt) enter_door();
            end
            ecc_pkg::M_EMERG_BETWEEN: begin
                orders = '0;
                if (!halt) car_mode = ecc_pkg::M_IDLE_BETWEEN;
            end
            ecc_pkg::M_IDLE_BETWEEN: begin
                if (halt) begin
                    car_mode = ecc_pkg::M_EMERG_BETWEEN;
                end else if (car_dir == ecc_pkg::DIR_UP) begin
                    if (orders_above(lf)) begin
                        enter_drive(ecc_pkg::DIR_UP);
                    end else if (orders_below(lf + 1)) begin
                        // reversing: the floor above becomes the car floor
                        enter_drive(ecc_pkg::DIR_DOWN);
                        if (lf + 1 < FLOORS) car_floor = lf + 1;
                    end
                end else if (car_dir == ecc_pkg::DIR_DOWN) begin
                    if (orders_below(lf)) begin
                        enter_drive(ecc_pkg::DIR_DOWN);
                    end else if (orders_above(lf - 1)) begin
                        enter_drive(ecc_pkg::DIR_UP);
                        if (lf > 0) car_floor = lf - 1;
                    end
                end
            end
            default: car_mode = ecc_pkg::M_INIT;
        endcase

        if (car_mode == ecc_pkg::M_DRIVE) r.motor_drive = car_dir;
        else if (car_mode == ecc_pkg::M_INIT) r.motor_drive = ecc_pkg::DIR_DOWN;
        else r.motor_drive = ecc_pkg::DIR_STOP;
        r.door_lamp       = (car_mode == ecc_pkg::M_DOOR || car_mode == ecc_pkg::M_EMERG_FLOOR);
        r.stop_lamp       = (car_mode == ecc_pkg::M_EMERG_FLOOR
                             || car_mode == ecc_pkg::M_EMERG_BETWEEN);
        r.floor_indicator = car_floor[1:0];
        r.mode            = car_mode;
        r.order_lamps     = orders;
        return r;
    endfunction

    // track config, predict on tick transfers, compare on status transfers
    always @(posedge i_clk) begin : watch
        ecc_pkg::t_out_item got;
        ecc_pkg::t_out_item want;
        ecc_pkg::t_in_item  tick;
        if (!i_rst_n) begin
            car_mode         = ecc_pkg::M_INIT;
            car_dir          = ecc_pkg::DIR_STOP;
            car_floor        = 0;
            leave_after_door = 1'b0;
            door_cnt         = 0;
            orders           = '0;
            door_ticks       = ecc_pkg::DOOR_TICKS_RST;
            status_q.delete();
            o_fail_count     = 0;
            o_ticks          = 0;
            o_modes_seen     = '0;
        end else begin
            if (i_cfg_we) door_ticks = i_cfg_wdata;

            if (out_mon.valid && out_mon.ready) begin
                got.motor_drive     = out_mon.motor_drive;
                got.door_lamp       = out_mon.door_lamp;
                got.stop_lamp       = out_mon.stop_lamp;
                got.floor_indicator = out_mon.floor_indicator;
                got.mode            = out_mon.mode;
                got.order_lamps     = out_mon.order_lamps;
                if (status_q.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("[%0t] status transfer with nothing predicted: mode %0d",
                                 $realtime, got.mode);
                end else begin
                    want = status_q.pop_front();
                    if (got.motor_drive !== want.motor_drive
                        || got.door_lamp !== want.door_lamp
                        || got.stop_lamp !== want.stop_lamp
                        || got.floor_indicator !== want.floor_indicator
                        || got.mode !== want.mode
                        || got.order_lamps !== want.order_lamps) begin
                        o_fail_count++;
                        if (o_fail_count <= 10) begin
                            $display("[%0t] status mismatch (motor door stop floor mode orders)",
                                     $realtime);
                            $display("    expected %0d %0b %0b %0d %0d %03h",
                                     want.motor_drive, want.door_lamp, want.stop_lamp,
                                     want.floor_indicator, want.mode, want.order_lamps);
                            $display("    actual   %0d %0b %0b %0d %0d %03h",
                                     got.motor_drive, got.door_lamp, got.stop_lamp,
                                     got.floor_indicator, got.mode, got.order_lamps);
                        end
                    end
                end
            end

            if (in_mon.valid && in_mon.ready) begin
                tick.stop_pressed = in_mon.stop_pressed;
                tick.at_floor     = in_mon.at_floor;
                tick.sensed_floor = in_mon.sensed_floor;
                tick.press_valid  = in_mon.press_valid;
                tick.press_button = in_mon.press_button;
                tick.press_floor  = in_mon.press_floor;
                want = advance_car(tick);
                status_q.push_back(want);
                o_modes_seen[want.mode] = 1'b1;
                o_ticks++;
            end
        end
        o_awaited = status_q.size();
    end

endmodule

@@ test/elevator_car_controller_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elevator_car_controller_core_tb
// drives sensor and button ticks with random gaps and status stalls through
// several door timer settings; the checker beside the block does the scoring
// ----------------------------------------------------------------------------
module elevator_car_controller_core_tb;

    // not a real button, the block must drop it
    localparam logic [1:0] B_NONE = 2'd3;
    localparam int         PHASES = 8;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        cfg_we;
    logic [15:0] cfg_wdata;

    ecc_in_if  tick_ch();
    ecc_out_if status_ch();

    int          fail_count;
    int          awaited;
    int          ticks;
    logic [7:0]  modes_seen;

    bit          calm;          // no gaps and no stalls
    int          stall_left;
    int          stop_hold;
    int          shaft_pos;     // even: at a floor, odd: between floors
    logic [1:0]  car_motor;
    int          settings_used;

    logic [15:0] door_setting [PHASES] = '{16'd2, 16'd1, 16'd0, 16'd5,
                                          16'd65535, 16'd13, 16'd3000, 16'd3};
    int          phase_len [PHASES] = '{150, 150, 100, 150, 60, 150, 60, 130};

    elevator_car_controller_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in        (tick_ch),
        .o_out       (status_ch)
    );

    elevator_car_controller_core_chk chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .in_mon       (tick_ch),
        .out_mon      (status_ch),
        .o_fail_count (fail_count),
        .o_awaited    (awaited),
        .o_ticks      (ticks),
        .o_modes_seen (modes_seen)
    );

    always #5 i_clk = ~i_clk;

    // idle length: mostly short, now and then long
    function automatic int idle_len();
        if ($urandom_range(0, 9) == 0) return int'($urandom_range(8, 40));
        return int'($urandom_range(1, 3));
    endfunction

    // status side: random stalls
    always @(negedge i_clk) begin
        if (calm) begin
            stall_left = 0;
            status_ch.ready = 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            status_ch.ready = 1'b0;
        end else if ($urandom_range(0, 9) < 7) begin
            status_ch.ready = 1'b1;
        end else begin
            stall_left = idle_len() - 1;
            status_ch.ready = 1'b0;
        end
    end

    // last motor command seen, moves the simulated car
    always @(posedge i_clk) begin
        if (status_ch.valid && status_ch.ready) car_motor <= status_ch.motor_drive;
    end

    // one tick transfer; starts and ends at a falling edge
    task automatic send_tick(input logic stop, input logic atf, input logic [1:0] sf,
                             input logic pv, input logic [1:0] pb, input logic [1:0] pf);
        int gap;
        gap = calm ? 0 : (($urandom_range(0, 3) == 0) ? idle_len() : 0);
        if (gap > 0) begin
            tick_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        tick_ch.valid        = 1'b1;
        tick_ch.stop_pressed = stop;
        tick_ch.at_floor     = atf;
        tick_ch.sensed_floor = sf;
        tick_ch.press_valid  = pv;
        tick_ch.press_button = pb;
        tick_ch.press_floor  = pf;
        @(posedge i_clk);
        while (!tick_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // door timer write once every status is back
    task automatic set_door_ticks(input logic [15:0] v);
        tick_ch.valid = 1'b0;
        while (awaited != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
        cfg_we    = 1'b1;
        cfg_wdata = v;
        @(negedge i_clk);
        cfg_we = 1'b0;
        settings_used++;
    endtask

    // ticks from a simulated shaft following the motor, with some noise
    task automatic run_random(input int count);
        logic       stop;
        logic       atf;
        logic [1:0] sf;
        logic       pv;
        logic [1:0] pb;
        logic [1:0] pf;
        for (int i = 0; i < count; i++) begin
            if (stop_hold > 0) begin
                stop_hold--;
                stop = 1'b1;
            end else if ($urandom_range(0, 49) == 0) begin
                stop_hold = int'($urandom_range(0, 9));
                stop = 1'b1;
            end else begin
                stop = 1'b0;
            end
            if ($urandom_range(0, 1) == 0) begin
                if (car_motor == ecc_pkg::DIR_UP && shaft_pos < 2 * (ecc_pkg::FLOORS_DEF - 1))
                    shaft_pos++;
                else if (car_motor == ecc_pkg::DIR_DOWN && shaft_pos > 0)
                    shaft_pos--;
            end
            if ($urandom_range(0, 9) == 0) begin
                atf = 1'($urandom_range(0, 1));
                sf  = 2'($urandom_range(0, 3));
                pv  = 1'($urandom_range(0, 1));
                pb  = 2'($urandom_range(0, 3));
                pf  = 2'($urandom_range(0, 3));
            end else begin
                atf = (shaft_pos % 2 == 0);
                sf  = 2'(shaft_pos / 2);
                pv  = ($urandom_range(0, 99) < 30);
                pb  = ($urandom_range(0, 19) == 0) ? B_NONE : 2'($urandom_range(0, 2));
                pf  = 2'($urandom_range(0, ecc_pkg::FLOORS_DEF - 1));
            end
            send_tick(stop, atf, sf, pv, pb, pf);
        end
    endtask

    // stimulus and verdict
    initial begin
        i_rst_n              = 1'b0;
        cfg_we               = 1'b0;
        cfg_wdata            = '0;
        tick_ch.valid        = 1'b0;
        tick_ch.stop_pressed = 1'b0;
        tick_ch.at_floor     = 1'b0;
        tick_ch.sensed_floor = '0;
        tick_ch.press_valid  = 1'b0;
        tick_ch.press_button = ecc_pkg::B_CAB;
        tick_ch.press_floor  = '0;
        status_ch.ready      = 1'b0;
        calm                 = 1'b0;
        stall_left           = 0;
        stop_hold            = 0;
        shaft_pos            = 0;
        car_motor            = ecc_pkg::DIR_STOP;
        settings_used        = 0;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: descent, top and bottom hall calls, emergencies, reversal
        set_door_ticks(16'd2);
        send_tick(1'b1, 1'b0, 2'd0, 1'b1, ecc_pkg::B_CAB,  2'd3);  // stop and press in init
        send_tick(1'b0, 1'b0, 2'd0, 1'b1, ecc_pkg::B_UP,   2'd1);
        send_tick(1'b0, 1'b1, 2'd3, 1'b0, ecc_pkg::B_CAB,  2'd0);  // first floor seen
        send_tick(1'b0, 1'b1, 2'd3, 1'b1, ecc_pkg::B_UP,   2'd3);  // hall up at top floor
        send_tick(1'b0, 1'b1, 2'd3, 1'b1, ecc_pkg::B_DOWN, 2'd0);  // hall down at bottom
        send_tick(1'b0, 1'b1, 2'd3, 1'b1, B_NONE,          2'd2);
        send_tick(1'b0, 1'b0, 2'd0, 1'b1, ecc_pkg::B_CAB,  2'd2);
        send_tick(1'b0, 1'b1, 2'd2, 1'b0, ecc_pkg::B_CAB,  2'd0);
        send_tick(1'b1, 1'b1, 2'd2, 1'b1, ecc_pkg::B_CAB,  2'd1);  // stop with door open
        send_tick(1'b1, 1'b1, 2'd2, 1'b0, ecc_pkg::B_CAB,  2'd0);
        send_tick(1'b0, 1'b1, 2'd2, 1'b1, ecc_pkg::B_UP,   2'd0);  // release at floor
        send_tick(1'b0, 1'b1, 2'd2, 1'b1, ecc_pkg::B_CAB,  2'd0);
        send_tick(1'b0, 1'b1, 2'd2, 1'b0, ecc_pkg::B_CAB,  2'd0);
        send_tick(1'b0, 1'b0, 2'd0, 1'b1, ecc_pkg::B_UP,   2'd3);
        send_tick(1'b1, 1'b0, 2'd0, 1'b0, ecc_pkg::B_CAB,  2'd0);  // stop between floors
        send_tick(1'b0, 1'b0, 2'd0, 1'b1, ecc_pkg::B_CAB,  2'd3);
        send_tick(1'b0, 1'b0, 2'd0, 1'b1, ecc_pkg::B_CAB,  2'd3);  // reverse between floors
        send_tick(1'b0, 1'b1, 2'd2, 1'b1, ecc_pkg::B_DOWN, 2'd0);
        send_tick(1'b0, 1'b0, 2'd0, 1'b0, ecc_pkg::B_CAB,  2'd0);
        send_tick(1'b0, 1'b1, 2'd3, 1'b0, ecc_pkg::B_CAB,  2'd0);
        send_tick(1'b0, 1'b1, 2'd3, 1'b0, ecc_pkg::B_CAB,  2'd0);
        send_tick(1'b0, 1'b1, 2'd3, 1'b0, ecc_pkg::B_CAB,  2'd0);
        send_tick(1'b0, 1'b1, 2'd0, 1'b1, ecc_pkg::B_DOWN, 2'd0);
        send_tick(1'b0, 1'b1, 2'd0, 1'b1, ecc_pkg::B_UP,   2'd0);
        send_tick(1'b0, 1'b1, 2'd0, 1'b0, ecc_pkg::B_CAB,  2'd0);
        shaft_pos = 0;

        // random phases, one door timer setting each
        for (int p = 0; p < PHASES; p++) begin
            set_door_ticks(door_setting[p]);
            calm = (p % 3 == 1);
            run_random(phase_len[p]);
        end
        calm = 1'b0;

        // drain
        tick_ch.valid = 1'b0;
        while (awaited != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);

        $display("run covered %0d ticks across %0d door timer settings", ticks, settings_used);
        $display("car modes reached (bit per mode): %b", modes_seen);
        if (fail_count == 0 && awaited == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // watchdog
    initial begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule

@@ elevator_car_controller_core.f @@
+incdir+src
src/ecc_pkg.sv
src/ecc_in_if.sv
src/ecc_out_if.sv
src/ecc_in_reg.sv
src/ecc_car_step.sv
src/elevator_car_controller_core.sv
test/elevator_car_controller_core_chk.sv
test/elevator_car_controller_core_tb.sv
